// ===== rtl/periodic_timer_slot_table_unit_assert.svh =====
// Assertion macros shared by the periodic timer slot table checkers.
`ifndef PERIODIC_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("periodic timer slot table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("periodic timer slot table assertion failed");

`endif

// ===== rtl/ptst_pkg.sv =====
// Shared types and constants of the periodic timer slot table.
`timescale 1ns / 1ps

package ptst_pkg;

  localparam int unsigned Slots       = 16;
  localparam logic [31:0] PeriodLimit = 32'h0001_0000;

  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 200;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [1:0] {
    ModeTick   = 2'd0,
    ModeAdd    = 2'd1,
    ModeRemove = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KindAdded   = 3'd0,
    KindBadArgs = 3'd1,
    KindFull    = 3'd2,
    KindRemoved = 3'd3,
    KindIgnored = 3'd4,
    KindFire    = 3'd5,
    KindTickEnd = 3'd6
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  tick;
    logic  idx_clr;
    logic  idx_inc;
    logic  fire;
    logic  add;
    logic  remove;
    logic  emit;
    kind_e kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       args_bad;
    logic       rm_valid;
    logic       idx_last;
    logic       hit_fire;
    logic       hit_free;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/ptst_ctrl.sv =====
// Controller state machine of the periodic timer slot table.
`timescale 1ns / 1ps

module ptst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ptst_pkg::stat_t  stat_i,
  output ptst_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StTick   = 3'd2;
  localparam logic [2:0] StAdd    = 3'd3;
  localparam logic [2:0] StResp   = 3'd4;

  logic [2:0]          state_q, state_d;
  ptst_pkg::kind_e     kind_q, kind_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        unique case (stat_i.mode)
          ptst_pkg::ModeTick: begin
            cmd_o.tick    = 1'b1;
            cmd_o.idx_clr = 1'b1;
            state_d       = StTick;
          end
          ptst_pkg::ModeAdd: begin
            if (stat_i.args_bad) begin
              kind_d  = ptst_pkg::KindBadArgs;
              state_d = StResp;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = StAdd;
            end
          end
          ptst_pkg::ModeRemove: begin
            cmd_o.remove = stat_i.rm_valid;
            kind_d  = stat_i.rm_valid ? ptst_pkg::KindRemoved : ptst_pkg::KindIgnored;
            state_d = StResp;
          end
          default: begin
            // The unused mode produces nothing.
            state_d = StIdle;
          end
        endcase
      end
      StTick: begin
        if (!stat_i.hit_fire || stat_i.out_free) begin
          if (stat_i.hit_fire) begin
            cmd_o.fire = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.kind = ptst_pkg::KindFire;
          end
          if (stat_i.idx_last) begin
            kind_d  = ptst_pkg::KindTickEnd;
            state_d = StResp;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      StAdd: begin
        if (stat_i.hit_free) begin
          if (stat_i.out_free) begin
            cmd_o.add  = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.kind = ptst_pkg::KindAdded;
            state_d    = StIdle;
          end
        end else if (stat_i.idx_last) begin
          kind_d  = ptst_pkg::KindFull;
          state_d = StResp;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      StResp: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = kind_q;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= ptst_pkg::KindAdded;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== rtl/ptst_datapath.sv =====
// Slot table, tick counter, scan index and output register of the timer table.
`timescale 1ns / 1ps

module ptst_datapath #(
  parameter int unsigned SLOTS = ptst_pkg::Slots
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptst_pkg::cmd_t                  cmd_i,
  output ptst_pkg::stat_t                 stat_o,
  input  logic [ptst_pkg::InDataW-1:0]    in_data_i,
  input  logic [ptst_pkg::InUserW-1:0]    in_user_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptst_pkg::OutDataW-1:0]   out_data_o,
  output logic [ptst_pkg::OutUserW-1:0]   out_user_o,
  output logic                            out_last_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Captured input transaction.
  logic [1:0]  mode_q;
  logic [31:0] handler_q, period_q, arg_a_q, arg_b_q, arg_c_q, arg_d_q;
  logic [7:0]  sidx_q;

  logic [31:0] counter_q;
  logic [IdxW-1:0] scan_q;

  logic [31:0] tab_handler_q  [SLOTS];
  logic [15:0] tab_period_q   [SLOTS];
  logic [31:0] tab_deadline_q [SLOTS];
  logic [31:0] tab_arg_a_q    [SLOTS];
  logic [31:0] tab_arg_b_q    [SLOTS];
  logic [31:0] tab_arg_c_q    [SLOTS];
  logic [31:0] tab_arg_d_q    [SLOTS];

  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [5:0]  out_slot_q;
  logic [31:0] out_handler_q, out_a_q, out_b_q, out_c_q, out_d_q, out_tick_q;
  logic        out_last_q;

  logic [31:0] cur_handler, cur_deadline;
  logic [IdxW-1:0] rm_idx;
  logic        out_free;
  logic        is_fire;
  logic [5:0]  slot_sel;

  assign cur_handler  = tab_handler_q[scan_q];
  assign cur_deadline = tab_deadline_q[scan_q];
  assign rm_idx       = sidx_q[IdxW-1:0];
  assign out_free     = !out_valid_q || out_ready_i;
  assign is_fire      = (cmd_i.kind == ptst_pkg::KindFire);

  always_comb begin
    stat_o          = '0;
    stat_o.mode     = mode_q;
    stat_o.args_bad = (handler_q == 32'd0) || (period_q == 32'd0) ||
                      (period_q >= ptst_pkg::PeriodLimit);
    stat_o.rm_valid = (sidx_q < 8'(SLOTS));
    stat_o.idx_last = (scan_q == IdxW'(SLOTS - 1));
    stat_o.hit_fire = (cur_handler != 32'd0) && (cur_deadline < counter_q);
    stat_o.hit_free = (cur_handler == 32'd0) && (cur_deadline == 32'd0);
    stat_o.out_free = out_free;
  end

  always_comb begin
    unique case (cmd_i.kind)
      ptst_pkg::KindAdded,
      ptst_pkg::KindFire:    slot_sel = 6'(scan_q);
      ptst_pkg::KindRemoved: slot_sel = sidx_q[5:0];
      default:               slot_sel = 6'd0;
    endcase
  end

  // Input capture and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      handler_q <= in_data_i[31:0];
      period_q  <= in_data_i[63:32];
      arg_a_q   <= in_data_i[95:64];
      arg_b_q   <= in_data_i[127:96];
      arg_c_q   <= in_data_i[159:128];
      arg_d_q   <= in_data_i[191:160];
      sidx_q    <= in_data_i[199:192];
      mode_q    <= in_user_i;
    end
    if (cmd_i.emit) begin
      out_kind_q    <= cmd_i.kind;
      out_slot_q    <= slot_sel;
      out_handler_q <= is_fire ? cur_handler : 32'd0;
      out_a_q       <= is_fire ? tab_arg_a_q[scan_q] : 32'd0;
      out_b_q       <= is_fire ? tab_arg_b_q[scan_q] : 32'd0;
      out_c_q       <= is_fire ? tab_arg_c_q[scan_q] : 32'd0;
      out_d_q       <= is_fire ? tab_arg_d_q[scan_q] : 32'd0;
      out_tick_q    <= counter_q;
      out_last_q    <= !is_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        tab_handler_q[i]  <= '0;
        tab_period_q[i]   <= '0;
        tab_deadline_q[i] <= '0;
        tab_arg_a_q[i]    <= '0;
        tab_arg_b_q[i]    <= '0;
        tab_arg_c_q[i]    <= '0;
        tab_arg_d_q[i]    <= '0;
      end
    end else begin
      if (cmd_i.tick) begin
        counter_q <= counter_q + 32'd1;
      end
      if (cmd_i.idx_clr) begin
        scan_q <= '0;
      end else if (cmd_i.idx_inc) begin
        scan_q <= scan_q + IdxW'(1);
      end
      if (cmd_i.fire) begin
        tab_deadline_q[scan_q] <= counter_q + 32'(tab_period_q[scan_q]);
      end
      if (cmd_i.add) begin
        tab_handler_q[scan_q]  <= handler_q;
        tab_period_q[scan_q]   <= period_q[15:0];
        tab_deadline_q[scan_q] <= counter_q + period_q;
        tab_arg_a_q[scan_q]    <= arg_a_q;
        tab_arg_b_q[scan_q]    <= arg_b_q;
        tab_arg_c_q[scan_q]    <= arg_c_q;
        tab_arg_d_q[scan_q]    <= arg_d_q;
      end
      if (cmd_i.remove) begin
        tab_handler_q[rm_idx]  <= '0;
        tab_deadline_q[rm_idx] <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {2'b00, out_tick_q, out_d_q, out_c_q, out_b_q, out_a_q,
                        out_handler_q, out_slot_q};

endmodule

// ===== rtl/periodic_timer_slot_table_unit.sv =====
// Top level of the periodic timer slot table.
//
//   channel  direction  tdata / tuser / tlast
//   s_axis   in         handler, period, arg_a..arg_d, slot_index / mode / -
//   m_axis   out        slot, fired_handler, out_arg_a..d, tick_now / kind / last
//
// A remove answers from the response state that follows decode. An add or a tick walks the slot
// table one slot per cycle unless a stalled output holds the scan: a tick scans every slot up to
// its tick-end result, and an add stops at the first free slot or reports the table full.
// Reset clears the table and tick counter at once; no clearing pass follows.
// A stalled output holds the scan on a slot that has a result to deliver.
`timescale 1ns / 1ps

module periodic_timer_slot_table_unit #(
  parameter int unsigned SLOTS = ptst_pkg::Slots
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] handler, [63:32] period, [95:64] arg_a, [127:96] arg_b,
  // [159:128] arg_c, [191:160] arg_d, [199:192] slot_index
  input  logic [ptst_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [1:0] mode
  input  logic [ptst_pkg::InUserW-1:0]    s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [5:0] slot, [37:6] fired_handler, [69:38] out_arg_a, [101:70] out_arg_b,
  // [133:102] out_arg_c, [165:134] out_arg_d, [197:166] tick_now, [199:198] zero
  output logic [ptst_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [2:0] kind
  output logic [ptst_pkg::OutUserW-1:0]   m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  ptst_pkg::cmd_t  cmd;
  ptst_pkg::stat_t stat;

  ptst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptst_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== rtl/ptst_checker.sv =====
// Port-level assertions of the periodic timer slot table and their bind.
`timescale 1ns / 1ps
`include "periodic_timer_slot_table_unit_assert.svh"

module ptst_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ptst_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input logic [ptst_pkg::OutUserW-1:0]   m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);

  logic in_acc;
  logic is_fire;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_fire = (m_axis_tuser_o == ptst_pkg::KindFire);

  // A stalled result holds until it is taken.
  `PTST_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // The block works on one transaction at a time.
  `PTST_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready_o)

  // Only fire results leave the run open.
  `PTST_ASSERT_IMP(a_last_kind, m_axis_tvalid_o, m_axis_tlast_o == !is_fire)

  // A slot only fires while it holds a handler.
  `PTST_ASSERT_IMP(a_fire_handler, m_axis_tvalid_o && is_fire,
    m_axis_tdata_o[37:6] != 32'd0)

endmodule

bind periodic_timer_slot_table_unit ptst_checker u_ptst_checker (.*);
